[rtl/core/fdt_pkg.sv]
// Shared types and constants for the framebuffer dirty tile tracker.
`default_nettype none

package fdt_pkg;

  // Default geometry of the tracked frame.
  localparam int SCREEN_WIDTH_DEF = 256;
  localparam int TILE_SIZE_DEF    = 8;
  localparam int TILE_COLS_DEF    = 32;
  localparam int TILE_ROWS_DEF    = 16;

  // Field widths fixed by the pixel and tile formats.
  localparam int X_W     = 8;
  localparam int Y_W     = 7;
  localparam int VAL_W   = 2;
  localparam int COL_W   = 5;
  localparam int ROW_W   = 4;
  localparam int X_SPAN  = 1 << X_W;
  localparam int Y_SPAN  = 1 << Y_W;
  localparam int ADDR_W  = X_W + Y_W;
  localparam int ENTRY_W = VAL_W + 1;

  // Depths of the decoupling queues.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef enum logic [0:0] {
    REQ_SCAN   = 1'b0,
    REQ_COMMIT = 1'b1
  } req_e;

  typedef struct packed {
    req_e             req_type;
    logic [X_W-1:0]   pixel_x;
    logic [Y_W-1:0]   pixel_y;
    logic [VAL_W-1:0] pixel_value;
    logic             commit_tile;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] tile_col;
    logic [ROW_W-1:0] tile_row;
    logic             tile_dirty;
    logic             frame_last;
  } tile_t;

  // A classified pixel operation handed from the front to the back.
  typedef struct packed {
    req_e              kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [X_W-1:0]    col;
    logic [ROW_W-1:0]  row;
    logic              first;
    logic              last;
    logic              frame_last;
  } op_t;

endpackage

`default_nettype wire

[rtl/core/framebuffer_dirty_tile_tracker.sv]
// Top level of the framebuffer dirty tile tracker.
// Throughput: one pixel beat per cycle while full is low; each beat kept by the
// front end takes one store access in the back end.
// Reset: dirty flags and queues clear at once; then a clearing pass over all
// FRAME_W * FRAME_H store entries (32768 by default) marks the store never committed.
// During that pass full is held high; afterwards every tile scans dirty until committed.
`default_nettype none

module framebuffer_dirty_tile_tracker #(
  parameter int SCREEN_WIDTH = fdt_pkg::SCREEN_WIDTH_DEF,
  parameter int TILE_SIZE    = fdt_pkg::TILE_SIZE_DEF,
  parameter int TILE_COLS    = fdt_pkg::TILE_COLS_DEF,
  parameter int TILE_ROWS    = fdt_pkg::TILE_ROWS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  fdt_pkg::pixel_t pix_i,
  output logic            empty,
  input  logic            pop,
  output fdt_pkg::tile_t  tile_o
);

  import fdt_pkg::*;

  // Reachable frame: bounded by the screen, the tile grid and the coordinate widths.
  localparam int GRID_W      = TILE_COLS * TILE_SIZE;
  localparam int GRID_H      = TILE_ROWS * TILE_SIZE;
  localparam int W_LIM       = (SCREEN_WIDTH < GRID_W) ? SCREEN_WIDTH : GRID_W;
  localparam int FRAME_W     = (W_LIM < X_SPAN) ? W_LIM : X_SPAN;
  localparam int FRAME_H     = (GRID_H < Y_SPAN) ? GRID_H : Y_SPAN;
  localparam int STORE_DEPTH = FRAME_W * FRAME_H;
  localparam int FLAG_DEPTH  = (FRAME_W + TILE_SIZE - 1) / TILE_SIZE;

  logic   op_push, mid_full, mid_empty, mid_pop;
  op_t    op_in, op_head;
  logic   out_push, out_full, clearing;
  tile_t  tile_res;

  // A beat is refused while the store is being cleared or the middle queue is full.
  assign full = mid_full || clearing;

  fdt_front #(
    .FRAME_W   (FRAME_W),
    .FRAME_H   (FRAME_H),
    .TILE_SIZE (TILE_SIZE),
    .TILE_COLS (TILE_COLS),
    .TILE_ROWS (TILE_ROWS)
  ) u_front (
    .pix_i     (pix_i),
    .take_i    (push && !full),
    .op_push_o (op_push),
    .op_o      (op_in)
  );

  // Middle queue decouples classification from the store pipeline.
  fdt_fifo #(
    .T     (op_t),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .pop_i   (mid_pop),
    .data_o  (op_head),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  fdt_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .FLAG_DEPTH  (FLAG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .op_i        (op_head),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .tile_o      (tile_res),
    .clearing_o  (clearing)
  );

  // Output queue lets finished tiles wait without stalling the compare stage.
  fdt_fifo #(
    .T     (tile_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (tile_res),
    .pop_i   (pop),
    .data_o  (tile_o),
    .full_o  (out_full),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

[rtl/core/fdt_fifo.sv]
// Small synchronous queue with registered storage and occupancy count.
`default_nettype none

module fdt_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fdt_front.sv]
// Front end: bounds check, tile position decode and store address for each pixel.
`default_nettype none

module fdt_front #(
  parameter int FRAME_W   = 256,
  parameter int FRAME_H   = 128,
  parameter int TILE_SIZE = 8,
  parameter int TILE_COLS = 32,
  parameter int TILE_ROWS = 16
) (
  input  fdt_pkg::pixel_t pix_i,
  input  logic            take_i,
  output logic            op_push_o,
  output fdt_pkg::op_t    op_o
);

  import fdt_pkg::*;

  localparam int CMP_W = 10;

  // Per-coordinate tile tables, built at elaboration.
  logic [X_W-1:0]    col_lut [X_SPAN];
  logic [Y_W-1:0]    row_lut [Y_SPAN];
  logic [X_SPAN-1:0] x_first, x_last;
  logic [Y_SPAN-1:0] y_first, y_last;

  for (genvar g = 0; g < X_SPAN; g++) begin : g_xlut
    assign col_lut[g] = X_W'(g / TILE_SIZE);
    assign x_first[g] = ((g % TILE_SIZE) == 0);
    assign x_last[g]  = ((g % TILE_SIZE) == TILE_SIZE - 1);
  end

  for (genvar g = 0; g < Y_SPAN; g++) begin : g_ylut
    assign row_lut[g] = Y_W'(g / TILE_SIZE);
    assign y_first[g] = ((g % TILE_SIZE) == 0);
    assign y_last[g]  = ((g % TILE_SIZE) == TILE_SIZE - 1);
  end

  logic              in_frame;
  logic [ADDR_W:0]   row_base;
  logic [X_W-1:0]    col;
  logic [Y_W-1:0]    row;

  assign in_frame = ({1'b0, pix_i.pixel_x} < (X_W + 1)'(FRAME_W)) &&
                    ({1'b0, pix_i.pixel_y} < (Y_W + 1)'(FRAME_H));
  assign row_base = (ADDR_W + 1)'(pix_i.pixel_y) * (ADDR_W + 1)'(FRAME_W);
  assign col      = col_lut[pix_i.pixel_x];
  assign row      = row_lut[pix_i.pixel_y];

  always_comb begin
    op_o.kind       = pix_i.req_type;
    op_o.addr       = row_base[ADDR_W-1:0] + ADDR_W'(pix_i.pixel_x);
    op_o.value      = pix_i.pixel_value;
    op_o.col        = col;
    op_o.row        = row[ROW_W-1:0];
    op_o.first      = x_first[pix_i.pixel_x] && y_first[pix_i.pixel_y];
    op_o.last       = x_last[pix_i.pixel_x] && y_last[pix_i.pixel_y];
    op_o.frame_last = (CMP_W'(col) == CMP_W'(TILE_COLS - 1)) &&
                      (CMP_W'(row) == CMP_W'(TILE_ROWS - 1));
  end

  // Commits to unselected tiles and out-of-frame pixels change nothing and are dropped here.
  assign op_push_o = take_i && in_frame &&
                     ((pix_i.req_type == REQ_SCAN) || pix_i.commit_tile);

endmodule

`default_nettype wire

[rtl/core/fdt_back.sv]
// Back end: reference store, clearing pass, compare stage and per-column dirty flags.
`default_nettype none

module fdt_back #(
  parameter int STORE_DEPTH = 32768,
  parameter int FLAG_DEPTH  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_empty_i,
  input  fdt_pkg::op_t  op_i,
  output logic          mid_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output fdt_pkg::tile_t tile_o,
  output logic          clearing_o
);

  import fdt_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FW = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;

  logic [ENTRY_W-1:0]    store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]    rd_q;
  logic                  clr_q;
  logic [AW-1:0]         clr_addr_q;
  logic                  s2_valid_q;
  op_t                   s2_op_q;
  logic [FLAG_DEPTH-1:0] flags_q;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  emits, leave, advance, mid_pop;
  logic                  mismatch, acc;
  logic [FW-1:0]         flag_idx;

  // Clearing pass marks every entry as never committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign clearing_o = clr_q;

  // Stage two holds one operation; it leaves unless its result has no room.
  assign emits   = (s2_op_q.kind == REQ_SCAN) && s2_op_q.last;
  assign leave   = s2_valid_q && (!emits || !out_full_i);
  assign advance = !s2_valid_q || leave;
  assign mid_pop = !clr_q && !mid_empty_i && advance;
  assign mid_pop_o = mid_pop;

  assign mem_we    = clr_q || (mid_pop && (op_i.kind == REQ_COMMIT));
  assign mem_waddr = clr_q ? clr_addr_q : op_i.addr[AW-1:0];
  assign mem_wdata = clr_q ? '0 : {1'b1, op_i.value};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mid_pop) begin
      rd_q    <= store_mem[op_i.addr[AW-1:0]];
      s2_op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= mid_pop;
    end
  end

  assign flag_idx = s2_op_q.col[FW-1:0];
  assign mismatch = !rd_q[ENTRY_W-1] || (rd_q[VAL_W-1:0] != s2_op_q.value);
  assign acc      = s2_op_q.first ? mismatch : (flags_q[flag_idx] || mismatch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (leave && (s2_op_q.kind == REQ_SCAN)) begin
      flags_q[flag_idx] <= s2_op_q.last ? 1'b0 : acc;
    end
  end

  assign out_push_o        = leave && emits;
  assign tile_o.tile_col   = s2_op_q.col[COL_W-1:0];
  assign tile_o.tile_row   = s2_op_q.row;
  assign tile_o.tile_dirty = acc;
  assign tile_o.frame_last = s2_op_q.frame_last;

`ifndef ASSERT_OFF
  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !mid_pop)
    else $error("operation taken during clearing pass");

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into full output queue");

  a_stalled_op_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !leave) |=> (s2_valid_q && $stable(s2_op_q) && $stable(rd_q)))
    else $error("stalled compare stage lost its operation");
`endif

endmodule

`default_nettype wire
